### rtl/tcb_pkg.sv
package tcb_pkg;

  typedef enum logic [2:0] {
    CMD_TEXEL   = 3'd0,
    CMD_SHADE   = 3'd1,
    CMD_RECOLOR = 3'd2,
    CMD_BLEND   = 3'd3,
    CMD_START   = 3'd4,
    CMD_PIXEL   = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_PLAIN         = 3'd0,
    MODE_SRC_HIGH      = 3'd1,
    MODE_DEST_HIGH     = 3'd2,
    MODE_RECOLOR       = 3'd3,
    MODE_RECOLOR_BLEND = 3'd4
  } mode_e;

  localparam logic [1:0] CFG_CENTER_ROW  = 2'd0;
  localparam logic [1:0] CFG_VIEW_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_VIEW_TOP    = 2'd2;
  localparam logic [1:0] CFG_VIEW_LEFT   = 2'd3;

  localparam logic [9:0]  CENTER_ROW_RST  = 10'd100;
  localparam logic [10:0] VIEW_HEIGHT_RST = 11'd168;

  // texel index reduction: q = (t * recip) >> MOD_SHIFT, then one correction
  localparam int MOD_SHIFT = 24;
  localparam int TPROD_W   = 34;
  localparam int Q_W       = 10;

  localparam int FIFO_DEPTH = 8;

  typedef struct packed {
    logic [2:0]         command;
    logic [15:0]        table_index;
    logic [7:0]         table_value;
    logic [9:0]         first_row;
    logic [9:0]         last_row;
    logic [9:0]         view_column;
    logic signed [31:0] texture_middle;
    logic signed [31:0] inverse_scale;
    logic [2:0]         draw_mode;
    logic [7:0]         dest_pixel;
  } req_t;

  typedef struct packed {
    logic [9:0]  center_row;
    logic [10:0] view_height;
    logic [9:0]  view_top;
    logic [9:0]  view_left;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    cmd_e               cmd;
    logic [15:0]        idx;
    logic [7:0]         val;
    mode_e              mode;
    logic [7:0]         dest;
    logic [10:0]        row;
    logic [10:0]        col;
    logic               last;
    logic [15:0]        tpos;
    logic [TPROD_W-1:0] tprod;
  } item_t;

  typedef struct packed {
    logic [10:0] row;
    logic [10:0] col;
    logic [7:0]  pix;
    logic        last;
  } result_t;

endpackage

### rtl/tcb_if.sv
interface tcb_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [15:0]        table_index;
  logic [7:0]         table_value;
  logic [9:0]         first_row;
  logic [9:0]         last_row;
  logic [9:0]         view_column;
  logic signed [31:0] texture_middle;
  logic signed [31:0] inverse_scale;
  logic [2:0]         draw_mode;
  logic [7:0]         dest_pixel;

  modport source (
    output valid, command, table_index, table_value, first_row, last_row,
           view_column, texture_middle, inverse_scale, draw_mode, dest_pixel,
    input  ready
  );

  modport sink (
    input  valid, command, table_index, table_value, first_row, last_row,
           view_column, texture_middle, inverse_scale, draw_mode, dest_pixel,
    output ready
  );
endinterface

interface tcb_res_if;
  logic        valid;
  logic        ready;
  logic [10:0] screen_row;
  logic [10:0] screen_column;
  logic [7:0]  pixel_value;
  logic        last_pixel;

  modport source (
    output valid, screen_row, screen_column, pixel_value, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, screen_row, screen_column, pixel_value, last_pixel,
    output ready
  );
endinterface

### rtl/tcb_ram.sv
module tcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/tcb_ctrl.sv
module tcb_ctrl #(
  parameter int TEXEL_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  tcb_pkg::req_t  req,
  input  tcb_pkg::cfg_t  cfg,
  output tcb_pkg::item_t item,
  output logic           busy
);

  localparam int RECIP = (1 << tcb_pkg::MOD_SHIFT) / TEXEL_DEPTH;

  logic [31:0]        tex_position;
  logic [31:0]        tex_step;
  logic [9:0]         current_row;
  logic [9:0]         end_row;
  logic [9:0]         drawn_column;
  tcb_pkg::mode_e     active_mode;
  logic               column_active;
  logic [31:0]        start_mid;
  logic [31:0]        start_prod;

  tcb_pkg::cmd_e      cmd;
  tcb_pkg::mode_e     start_mode;
  logic               trim;
  logic signed [11:0] first_t;
  logic signed [11:0] last_t;
  logic signed [11:0] diff;
  logic [31:0]        prod;
  logic               nonempty;
  logic               start_acc;
  logic               pixel_acc;
  logic               at_end;
  tcb_pkg::item_t     item_next;

  always_comb begin
    cmd = tcb_pkg::cmd_e'(req.command);
    if (req.draw_mode > tcb_pkg::MODE_RECOLOR_BLEND) begin
      start_mode = tcb_pkg::MODE_PLAIN;
    end else begin
      start_mode = tcb_pkg::mode_e'(req.draw_mode);
    end
    trim = (start_mode == tcb_pkg::MODE_SRC_HIGH) || (start_mode == tcb_pkg::MODE_DEST_HIGH);
    first_t = $signed({2'b00, req.first_row});
    if (trim && req.first_row == 10'd0) begin
      first_t = 12'sd1;
    end
    last_t = $signed({2'b00, req.last_row});
    if (trim && {1'b0, req.last_row} == cfg.view_height - 11'd1) begin
      last_t = $signed({1'b0, cfg.view_height}) - 12'sd2;
    end
    nonempty = last_t >= first_t;
    diff = first_t - $signed({2'b00, cfg.center_row});
    prod = 32'(diff) * 32'(req.inverse_scale);
    start_acc = accept && cmd == tcb_pkg::CMD_START;
    pixel_acc = accept && cmd == tcb_pkg::CMD_PIXEL && column_active;
    at_end = current_row == end_row;
  end

  always_comb begin
    item_next.cmd   = cmd;
    item_next.idx   = req.table_index;
    item_next.val   = req.table_value;
    item_next.mode  = active_mode;
    item_next.dest  = req.dest_pixel;
    item_next.row   = 11'(current_row) + 11'(cfg.view_top);
    item_next.col   = 11'(drawn_column) + 11'(cfg.view_left);
    item_next.last  = at_end;
    item_next.tpos  = tex_position[31:16];
    item_next.tprod = tcb_pkg::TPROD_W'(tex_position[31:16]) * tcb_pkg::TPROD_W'(RECIP);
    case (cmd)
      tcb_pkg::CMD_TEXEL,
      tcb_pkg::CMD_SHADE,
      tcb_pkg::CMD_RECOLOR,
      tcb_pkg::CMD_BLEND: item_next.valid = accept;
      tcb_pkg::CMD_PIXEL: item_next.valid = pixel_acc;
      default:            item_next.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_position  <= '0;
      tex_step      <= '0;
      current_row   <= '0;
      end_row       <= '0;
      drawn_column  <= '0;
      active_mode   <= tcb_pkg::MODE_PLAIN;
      column_active <= 1'b0;
      busy          <= 1'b0;
      item.valid    <= 1'b0;
    end else begin
      item <= item_next;
      busy <= start_acc && nonempty;
      if (busy) begin
        tex_position <= start_mid + start_prod;
      end
      if (start_acc) begin
        column_active <= nonempty;
        if (nonempty) begin
          tex_step     <= req.inverse_scale;
          current_row  <= first_t[9:0];
          end_row      <= last_t[9:0];
          drawn_column <= req.view_column;
          active_mode  <= start_mode;
        end
      end else if (pixel_acc) begin
        tex_position <= tex_position + tex_step;
        if (at_end) begin
          column_active <= 1'b0;
        end else begin
          current_row <= current_row + 10'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    start_mid  <= req.texture_middle;
    start_prod <= prod;
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !accept)
    else $error("transaction taken while start position is pending");

  a_last_ends_column: assert property (@(posedge clk) disable iff (rst)
    (pixel_acc && at_end) |=> !column_active)
    else $error("column still active after its last pixel");

endmodule

### rtl/tcb_lookup.sv
module tcb_lookup #(
  parameter int TEXEL_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  tcb_pkg::item_t   s1,
  output logic             res_valid,
  output tcb_pkg::result_t res
);

  localparam int TAW = $clog2(TEXEL_DEPTH);

  tcb_pkg::item_t s2, s3, s4, s5;
  logic [7:0]     s3_texel;
  logic [7:0]     s5_shade;

  logic [tcb_pkg::Q_W-1:0] q;
  logic [16:0]    qd, r0, rmod;
  logic [TAW-1:0] texel_raddr;
  logic [7:0]     texel_rd, recolor_rd, shade_rd, blend_rd;
  logic [7:0]     shade_raddr;
  logic [15:0]    blend_raddr;
  logic           texel_we, recolor_we, shade_we, blend_we;

  // stage 1: texel index and texel store
  always_comb begin
    q    = s1.tprod[tcb_pkg::MOD_SHIFT +: tcb_pkg::Q_W];
    qd   = 17'(q) * 17'(TEXEL_DEPTH);
    r0   = 17'(s1.tpos) - qd;
    rmod = (r0 >= 17'(TEXEL_DEPTH)) ? r0 - 17'(TEXEL_DEPTH) : r0;
    if (s1.mode == tcb_pkg::MODE_RECOLOR) begin
      texel_raddr = rmod[TAW-1:0];
    end else begin
      texel_raddr = TAW'(s1.tpos[6:0]);
    end
    texel_we = s1.valid && s1.cmd == tcb_pkg::CMD_TEXEL &&
               32'(s1.idx) < 32'(TEXEL_DEPTH);
  end

  tcb_ram #(.WIDTH(8), .DEPTH(TEXEL_DEPTH)) u_texel (
    .clk   (clk),
    .we    (texel_we),
    .waddr (s1.idx[TAW-1:0]),
    .wdata (s1.val),
    .raddr (texel_raddr),
    .rdata (texel_rd)
  );

  // stage 2: recolor map
  assign recolor_we = s2.valid && s2.cmd == tcb_pkg::CMD_RECOLOR && s2.idx[15:8] == 8'd0;

  tcb_ram #(.WIDTH(8), .DEPTH(256)) u_recolor (
    .clk   (clk),
    .we    (recolor_we),
    .waddr (s2.idx[7:0]),
    .wdata (s2.val),
    .raddr (texel_rd),
    .rdata (recolor_rd)
  );

  // stage 3: shade map
  always_comb begin
    if (s3.mode == tcb_pkg::MODE_RECOLOR || s3.mode == tcb_pkg::MODE_RECOLOR_BLEND) begin
      shade_raddr = recolor_rd;
    end else begin
      shade_raddr = s3_texel;
    end
  end

  assign shade_we = s3.valid && s3.cmd == tcb_pkg::CMD_SHADE && s3.idx[15:8] == 8'd0;

  tcb_ram #(.WIDTH(8), .DEPTH(256)) u_shade (
    .clk   (clk),
    .we    (shade_we),
    .waddr (s3.idx[7:0]),
    .wdata (s3.val),
    .raddr (shade_raddr),
    .rdata (shade_rd)
  );

  // stage 4: blend table
  always_comb begin
    if (s4.mode == tcb_pkg::MODE_SRC_HIGH) begin
      blend_raddr = {shade_rd, s4.dest};
    end else begin
      blend_raddr = {s4.dest, shade_rd};
    end
  end

  assign blend_we = s4.valid && s4.cmd == tcb_pkg::CMD_BLEND;

  tcb_ram #(.WIDTH(8), .DEPTH(65536)) u_blend (
    .clk   (clk),
    .we    (blend_we),
    .waddr (s4.idx),
    .wdata (s4.val),
    .raddr (blend_raddr),
    .rdata (blend_rd)
  );

  // stage 5: pick the final byte
  always_comb begin
    res_valid = s5.valid && s5.cmd == tcb_pkg::CMD_PIXEL;
    res.row   = s5.row;
    res.col   = s5.col;
    res.last  = s5.last;
    case (s5.mode)
      tcb_pkg::MODE_SRC_HIGH,
      tcb_pkg::MODE_DEST_HIGH,
      tcb_pkg::MODE_RECOLOR_BLEND: res.pix = blend_rd;
      default:                     res.pix = s5_shade;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
      s4.valid <= 1'b0;
      s5.valid <= 1'b0;
    end else begin
      s2 <= s1;
      s3 <= s2;
      s4 <= s3;
      s5 <= s4;
    end
  end

  always_ff @(posedge clk) begin
    s3_texel <= texel_rd;
    s5_shade <= shade_rd;
  end

endmodule

### rtl/tcb_fifo.sv
module tcb_fifo #(
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tcb_pkg::result_t push_data,
  input  logic             pop,
  output logic             valid,
  output tcb_pkg::result_t data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tcb_pkg::result_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign valid = count != '0;
  assign data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> count != CW'(DEPTH))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid)
    else $error("result queue underflow");

endmodule

### rtl/textured_column_blender.sv
// Throughput: one transaction per cycle while the queue has room for the results owed; a
// start command with rows to draw holds ready low for the one cycle that adds the start
// product into the texture position.
// The result queue and its credit count keep the five-stage texel/recolor/shade/blend
// lookup chain running while the result side stalls.
// Reset (rst, synchronous, active high) idles the column, clears the queue and restores the
// register defaults; table contents are undefined until loaded.
module textured_column_blender #(
  parameter int TEXEL_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  tcb_req_if.sink     request,
  tcb_res_if.source   result
);

  localparam int OCC_W = $clog2(tcb_pkg::FIFO_DEPTH + 1);

  tcb_pkg::cfg_t    cfg;
  tcb_pkg::req_t    req;
  tcb_pkg::item_t   item;
  tcb_pkg::result_t res, out_data;
  logic             res_valid;
  logic             busy;
  logic             accept;
  logic             pop;
  logic             s1_pixel;
  logic [OCC_W-1:0] occ;

  always_comb begin
    req.command        = request.command;
    req.table_index    = request.table_index;
    req.table_value    = request.table_value;
    req.first_row      = request.first_row;
    req.last_row       = request.last_row;
    req.view_column    = request.view_column;
    req.texture_middle = request.texture_middle;
    req.inverse_scale  = request.inverse_scale;
    req.draw_mode      = request.draw_mode;
    req.dest_pixel     = request.dest_pixel;
  end

  assign s1_pixel      = item.valid && item.cmd == tcb_pkg::CMD_PIXEL;
  assign request.ready = !busy &&
                         ((OCC_W + 1)'(occ) + (OCC_W + 1)'(s1_pixel)) <
                         (OCC_W + 1)'(tcb_pkg::FIFO_DEPTH);
  assign accept        = request.valid && request.ready;
  assign pop           = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_row  <= tcb_pkg::CENTER_ROW_RST;
      cfg.view_height <= tcb_pkg::VIEW_HEIGHT_RST;
      cfg.view_top    <= '0;
      cfg.view_left   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tcb_pkg::CFG_CENTER_ROW:  cfg.center_row  <= cfg_data[9:0];
        tcb_pkg::CFG_VIEW_HEIGHT: cfg.view_height <= cfg_data;
        tcb_pkg::CFG_VIEW_TOP:    cfg.view_top    <= cfg_data[9:0];
        tcb_pkg::CFG_VIEW_LEFT:   cfg.view_left   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // results owed: in the lookup chain or waiting in the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + OCC_W'(s1_pixel) - OCC_W'(pop);
    end
  end

  tcb_ctrl #(.TEXEL_DEPTH(TEXEL_DEPTH)) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .cfg    (cfg),
    .item   (item),
    .busy   (busy)
  );

  tcb_lookup #(.TEXEL_DEPTH(TEXEL_DEPTH)) u_lookup (
    .clk       (clk),
    .rst       (rst),
    .s1        (item),
    .res_valid (res_valid),
    .res       (res)
  );

  tcb_fifo #(.DEPTH(tcb_pkg::FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (pop),
    .valid     (result.valid),
    .data      (out_data)
  );

  assign result.screen_row    = out_data.row;
  assign result.screen_column = out_data.col;
  assign result.pixel_value   = out_data.pix;
  assign result.last_pixel    = out_data.last;

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(tcb_pkg::FIFO_DEPTH))
    else $error("more results owed than queue entries");

  a_valid_has_credit: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> occ != '0)
    else $error("result shown with no transaction owed");

endmodule
